// ===== src/lcc_pkg.sv =====
// Shared constants, types and helper functions for the card number check unit.
// No dependencies; every other file in src imports this package.
package lcc_pkg;

  // Field widths of the input and result transactions
  localparam int CardWidth       = 63;
  localparam int ClassWidth      = 2;
  localparam int DigitCountWidth = 5;
  localparam int SumWidth        = 8;
  localparam int TotalWidth      = 32;

  // Examined digit limit and tally width
  localparam int MaxDigits   = 19;
  localparam int TallyWidth  = 32;
  localparam int DigitCntW   = $clog2(MaxDigits + 1);

  // Decimal constants
  localparam int Radix       = 10;
  localparam int DigitWidth  = 4;
  localparam int FoldOffset  = 9;

  // Binary to BCD conversion: a chunk of input bits is shifted in per cycle
  localparam int ChunkBits   = 8;
  localparam int NumChunks   = (CardWidth + ChunkBits - 1) / ChunkBits;
  localparam int PadWidth    = NumChunks * ChunkBits;
  localparam int ChunkCntW   = (NumChunks > 1) ? $clog2(NumChunks) : 1;
  localparam int BcdDigits   = 19;
  localparam int BcdWidth    = BcdDigits * DigitWidth;
  localparam int ModWidth    = $clog2(Radix);

  typedef enum logic [ClassWidth-1:0] {
    CLASS_FOUR  = 2'd0,
    CLASS_FIVE  = 2'd1,
    CLASS_SIX   = 2'd2,
    CLASS_OTHER = 2'd3
  } card_class_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic convert;
    logic peel;
    logic commit;
  } lcc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic peel_last;
  } lcc_status_t;

  // Registered result payload
  typedef struct packed {
    logic                       is_valid;
    card_class_e                card_class;
    logic [DigitCountWidth-1:0] digit_count;
    logic [SumWidth-1:0]        luhn_sum;
    logic [TotalWidth-1:0]      valid_total;
    logic [TotalWidth-1:0]      invalid_total;
  } lcc_result_t;

  // Weighted digit: doubled on even positions, folded back below ten
  function automatic logic [DigitWidth-1:0] luhn_weight(input logic [DigitWidth-1:0] digit,
                                                        input logic dbl);
    logic [DigitWidth:0] twice;
    twice = {digit, 1'b0};
    if (!dbl) begin
      return digit;
    end else if (twice > (DigitWidth+1)'(FoldOffset)) begin
      return DigitWidth'(twice - (DigitWidth+1)'(FoldOffset));
    end else begin
      return DigitWidth'(twice);
    end
  endfunction

  // Class of the leading examined digit
  function automatic card_class_e class_of(input logic [DigitWidth-1:0] digit);
    card_class_e cls;
    case (digit)
      4'd4:    cls = CLASS_FOUR;
      4'd5:    cls = CLASS_FIVE;
      4'd6:    cls = CLASS_SIX;
      default: cls = CLASS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

// ===== src/lcc_card_if.sv =====
// Input channel of the card number check unit: one card number per transaction.
// Depends on lcc_pkg for the payload width.
interface lcc_card_if;
  import lcc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CardWidth-1:0] card_value;

  modport source (output valid, output card_value, input ready);
  modport sink   (input valid, input card_value, output ready);
endinterface

// ===== src/lcc_result_if.sv =====
// Result channel of the card number check unit: one check result per transaction.
// Depends on lcc_pkg for the payload widths.
interface lcc_result_if;
  import lcc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       is_valid;
  logic [ClassWidth-1:0]      card_class;
  logic [DigitCountWidth-1:0] digit_count;
  logic [SumWidth-1:0]        luhn_sum;
  logic [TotalWidth-1:0]      valid_total;
  logic [TotalWidth-1:0]      invalid_total;

  modport source (output valid, output is_valid, output card_class, output digit_count,
                  output luhn_sum, output valid_total, output invalid_total, input ready);
  modport sink   (input valid, input is_valid, input card_class, input digit_count,
                  input luhn_sum, input valid_total, input invalid_total, output ready);
endinterface

// ===== src/lcc_ctrl.sv =====
// Sequencing state machine of the card number check unit.
// Depends on lcc_pkg; drives lcc_datapath through command and status structs.
module lcc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lcc_pkg::lcc_status_t status_i,
  output lcc_pkg::lcc_cmd_t    cmd_o
);
  import lcc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PEEL,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [ChunkCntW-1:0] chunk_q;
  logic                 out_valid_q;
  logic                 commit_ok;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign commit_ok   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.convert = (state_q == ST_CONVERT);
    cmd_o.peel    = (state_q == ST_PEEL);
    cmd_o.commit  = (state_q == ST_FINISH) && commit_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // raise valid on a commit; otherwise drop the result once taken
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            chunk_q <= '0;
            state_q <= ST_CONVERT;
          end
        end
        ST_CONVERT: begin
          if (chunk_q == ChunkCntW'(NumChunks - 1)) begin
            state_q <= ST_PEEL;
          end else begin
            chunk_q <= chunk_q + 1'b1;
          end
        end
        ST_PEEL: begin
          if (status_i.peel_last) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (commit_ok) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lcc_datapath.sv =====
// Datapath of the card number check unit: BCD conversion, digit peeling,
// weighted sum, result register and saturating tallies. Depends on lcc_pkg.
module lcc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcc_pkg::lcc_cmd_t    cmd_i,
  output lcc_pkg::lcc_status_t status_o,
  input  logic [lcc_pkg::CardWidth-1:0] card_value_i,
  output lcc_pkg::lcc_result_t result_o
);
  import lcc_pkg::*;

  logic [PadWidth-1:0]   bin_q, bin_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [DigitCntW-1:0]  pos_q, pos_next;
  logic [SumWidth-1:0]   sum_q;
  logic [ModWidth-1:0]   mod_q, mod_d;
  logic [DigitWidth-1:0] top_q;
  logic [DigitWidth-1:0] digit;
  logic [DigitWidth-1:0] weight;
  logic [ModWidth:0]     mod_sum;

  logic                       is_valid_q;
  card_class_e                class_q;
  logic [DigitCountWidth-1:0] count_q;
  logic [SumWidth-1:0]        luhn_sum_q;
  logic [TallyWidth-1:0]      valid_tally_q;
  logic [TallyWidth-1:0]      invalid_tally_q;
  logic                       ok;

  // Shift-add-3 over one chunk of input bits
  always_comb begin
    logic [PadWidth-1:0] bin_v;
    logic [BcdWidth-1:0] bcd_v;
    bin_v = bin_q;
    bcd_v = bcd_q;
    for (int s = 0; s < ChunkBits; s++) begin
      for (int g = 0; g < BcdDigits; g++) begin
        if (bcd_v[g*DigitWidth +: DigitWidth] >= DigitWidth'(5)) begin
          bcd_v[g*DigitWidth +: DigitWidth] = bcd_v[g*DigitWidth +: DigitWidth] + DigitWidth'(3);
        end
      end
      bcd_v = {bcd_v[BcdWidth-2:0], bin_v[PadWidth-1]};
      bin_v = {bin_v[PadWidth-2:0], 1'b0};
    end
    bin_d = bin_v;
    bcd_d = bcd_v;
  end

  // Peel the lowest decimal digit; even positions are doubled
  assign digit    = bcd_q[DigitWidth-1:0];
  assign weight   = luhn_weight(digit, pos_q[0]);
  assign pos_next = pos_q + 1'b1;
  assign mod_sum  = (ModWidth+1)'(mod_q) + (ModWidth+1)'(weight);
  assign mod_d    = (mod_sum >= (ModWidth+1)'(Radix)) ?
                    ModWidth'(mod_sum - (ModWidth+1)'(Radix)) : ModWidth'(mod_sum);

  assign status_o.peel_last = (bcd_q[BcdWidth-1:DigitWidth] == '0) ||
                              (pos_next == DigitCntW'(MaxDigits));

  assign ok = (mod_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= PadWidth'(card_value_i);
      bcd_q <= '0;
      pos_q <= '0;
      sum_q <= '0;
      mod_q <= '0;
    end else if (cmd_i.convert) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end else if (cmd_i.peel) begin
      bcd_q <= {DigitWidth'(0), bcd_q[BcdWidth-1:DigitWidth]};
      pos_q <= pos_next;
      sum_q <= sum_q + SumWidth'(weight);
      mod_q <= mod_d;
      top_q <= digit;
    end
    if (cmd_i.commit) begin
      is_valid_q <= ok;
      class_q    <= class_of(top_q);
      count_q    <= DigitCountWidth'(pos_q);
      luhn_sum_q <= sum_q;
    end
  end

  // Saturating tallies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_tally_q   <= '0;
      invalid_tally_q <= '0;
    end else if (cmd_i.commit) begin
      if (ok && (valid_tally_q != '1)) begin
        valid_tally_q <= valid_tally_q + 1'b1;
      end
      if (!ok && (invalid_tally_q != '1)) begin
        invalid_tally_q <= invalid_tally_q + 1'b1;
      end
    end
  end

  always_comb begin
    result_o.is_valid      = is_valid_q;
    result_o.card_class    = class_q;
    result_o.digit_count   = count_q;
    result_o.luhn_sum      = luhn_sum_q;
    result_o.valid_total   = TotalWidth'(valid_tally_q);
    result_o.invalid_total = TotalWidth'(invalid_tally_q);
  end

endmodule

// ===== src/luhn_card_number_check_unit.sv =====
// Top level of the card number check unit (mod-10 check with running tallies).
// Depends on lcc_pkg, lcc_card_if, lcc_result_if, lcc_ctrl and lcc_datapath.
//
//   channel   | direction | handshake     | payload
//   ----------+-----------+---------------+--------------------------------------------
//   card_i    | in        | valid / ready | card_value[62:0]
//   result_o  | out       | valid / ready | is_valid, card_class, digit_count,
//             |           |               | luhn_sum, valid_total, invalid_total
//
// One transaction occupies the engine from accept to commit, N being the digit count (1..19):
// an accept step, binary-to-BCD conversion (8 input bits per cycle), peeling of each of
// the N digits and a commit into the result register.
// The result register parts the two sides: the next card is taken while a result waits,
// and the engine holds in its commit cycle only while an untaken result is still held.
// Reset clears the controller, the result valid flag and both tallies.
module luhn_card_number_check_unit (
  input logic        clk_i,
  input logic        rst_ni,
  lcc_card_if.sink   card_i,
  lcc_result_if.source result_o
);
  import lcc_pkg::*;

  lcc_cmd_t    cmd;
  lcc_status_t status;
  lcc_result_t result;

  // Sequence accept, conversion, peeling and commit
  lcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (card_i.valid),
    .in_ready_o  (card_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Convert, peel digits, accumulate and hold the result
  lcc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .card_value_i (card_i.card_value),
    .result_o     (result)
  );

  // Drive the result channel payload from the result register
  assign result_o.is_valid      = result.is_valid;
  assign result_o.card_class    = result.card_class;
  assign result_o.digit_count   = result.digit_count;
  assign result_o.luhn_sum      = result.luhn_sum;
  assign result_o.valid_total   = result.valid_total;
  assign result_o.invalid_total = result.invalid_total;

endmodule
